[hdl/ode_pkg.sv]
package ode_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int COEFF_WIDTH  = 16;
  localparam int EXT_BITS     = 16;
  localparam int LEVEL_W      = SAMPLE_WIDTH + EXT_BITS;
  localparam int HP_W         = SAMPLE_WIDTH + 8;
  localparam int HP_SUM_W     = HP_W + 4;
  localparam int MUL_W        = LEVEL_W + 1;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int SUM_W        = HP_W + LEVEL_W + 2;
  localparam int MIX_SHIFT    = SAMPLE_WIDTH - 1 + EXT_BITS;
  localparam int CFG_IDX_W    = 4;

  localparam logic [SAMPLE_WIDTH-1:0] UNITY = SAMPLE_WIDTH'(1 << (SAMPLE_WIDTH - 1));
  localparam logic signed [SAMPLE_WIDTH-1:0] HYST =
    SAMPLE_WIDTH'(((1 << SAMPLE_WIDTH) + 500) / 1000);
  localparam logic signed [HP_SUM_W-1:0] HP_MAX = HP_SUM_W'((64'sd1 <<< (HP_W - 1)) - 1);
  localparam logic signed [HP_SUM_W-1:0] HP_MIN = HP_SUM_W'(-(64'sd1 <<< (HP_W - 1)));
  localparam logic signed [SUM_W-1:0] MIX_HALF = SUM_W'(64'sd1 <<< (MIX_SHIFT - 1));
  localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [SUM_W-1:0] OUT_MIN = SUM_W'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

  localparam logic [SAMPLE_WIDTH-1:0] SUB_LEVEL_RST   = SAMPLE_WIDTH'(16384);
  localparam logic [SAMPLE_WIDTH-1:0] UPPER_LEVEL_RST = SAMPLE_WIDTH'(0);
  localparam logic [SAMPLE_WIDTH-1:0] DRY_LEVEL_RST   = SAMPLE_WIDTH'(22938);
  localparam logic [COEFF_WIDTH-1:0]  SMOOTH_RST      = COEFF_WIDTH'(136);
  localparam logic [COEFF_WIDTH-1:0]  ATTACK_RST      = COEFF_WIDTH'(679);
  localparam logic [COEFF_WIDTH-1:0]  RELEASE_RST     = COEFF_WIDTH'(68);
  localparam logic [COEFF_WIDTH-1:0]  HIGHPASS_RST    = COEFF_WIDTH'(65364);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE      = 4'd0,
    REG_SUB_LEVEL   = 4'd1,
    REG_UPPER_LEVEL = 4'd2,
    REG_DRY_LEVEL   = 4'd3,
    REG_SMOOTH      = 4'd4,
    REG_ATTACK      = 4'd5,
    REG_RELEASE     = 4'd6,
    REG_HIGHPASS    = 4'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MUL_SUB   = 3'd0,
    MUL_UPPER = 3'd1,
    MUL_DRY   = 3'd2,
    MUL_ENV   = 3'd3,
    MUL_HP    = 3'd4,
    MUL_T1    = 3'd5,
    MUL_T2    = 3'd6,
    MUL_T3    = 3'd7
  } mul_op_t;

  typedef enum logic [3:0] {
    WB_NONE  = 4'd0,
    WB_SUB   = 4'd1,
    WB_UPPER = 4'd2,
    WB_DRY   = 4'd3,
    WB_ENV   = 4'd4,
    WB_HP    = 4'd5,
    WB_T1    = 4'd6,
    WB_T2    = 4'd7,
    WB_T3    = 4'd8
  } wb_op_t;

  typedef struct packed {
    logic    load;
    logic    upd_div;
    mul_op_t mul_op;
    wb_op_t  wb_op;
    logic    emit;
    logic    pass;
  } cmd_t;

  typedef struct packed {
    logic enable;
    logic out_free;
  } status_t;

endpackage

[hdl/ode_ctrl.sv]
module ode_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  ode_pkg::status_t status,
  output ode_pkg::cmd_t    cmd
);
  import ode_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_SUB   = 12'b0000_0000_0010,
    ST_UPPER = 12'b0000_0000_0100,
    ST_DRY   = 12'b0000_0000_1000,
    ST_ENV   = 12'b0000_0001_0000,
    ST_HP    = 12'b0000_0010_0000,
    ST_T1    = 12'b0000_0100_0000,
    ST_T2    = 12'b0000_1000_0000,
    ST_T3    = 12'b0001_0000_0000,
    ST_ACC   = 12'b0010_0000_0000,
    ST_EMIT  = 12'b0100_0000_0000,
    ST_PASS  = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.load    = 1'b0;
    cmd.upd_div = 1'b0;
    cmd.mul_op  = MUL_SUB;
    cmd.wb_op   = WB_NONE;
    cmd.emit    = 1'b0;
    cmd.pass    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = status.enable ? ST_SUB : ST_PASS;
        end
      end
      ST_SUB: begin
        cmd.upd_div = 1'b1;
        cmd.mul_op  = MUL_SUB;
        state_next  = ST_UPPER;
      end
      ST_UPPER: begin
        cmd.mul_op = MUL_UPPER;
        cmd.wb_op  = WB_SUB;
        state_next = ST_DRY;
      end
      ST_DRY: begin
        cmd.mul_op = MUL_DRY;
        cmd.wb_op  = WB_UPPER;
        state_next = ST_ENV;
      end
      ST_ENV: begin
        cmd.mul_op = MUL_ENV;
        cmd.wb_op  = WB_DRY;
        state_next = ST_HP;
      end
      ST_HP: begin
        cmd.mul_op = MUL_HP;
        cmd.wb_op  = WB_ENV;
        state_next = ST_T1;
      end
      ST_T1: begin
        cmd.mul_op = MUL_T1;
        cmd.wb_op  = WB_HP;
        state_next = ST_T2;
      end
      ST_T2: begin
        cmd.mul_op = MUL_T2;
        cmd.wb_op  = WB_T1;
        state_next = ST_T3;
      end
      ST_T3: begin
        cmd.mul_op = MUL_T3;
        cmd.wb_op  = WB_T2;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.wb_op  = WB_T3;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_PASS: begin
        cmd.pass = 1'b1;
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/ode_datapath.sv]
module ode_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [ode_pkg::SAMPLE_WIDTH-1:0]    sample_in,
  input  logic                                cfg_valid,
  input  logic [ode_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ode_pkg::SAMPLE_WIDTH-1:0]    cfg_data,
  input  ode_pkg::cmd_t                       cmd,
  output ode_pkg::status_t                    status,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [ode_pkg::SAMPLE_WIDTH-1:0]    out_sample,
  output logic                                out_clipped
);
  import ode_pkg::*;

  logic                           enable;
  logic [SAMPLE_WIDTH-1:0]        sub_lvl, upper_lvl, dry_lvl;
  logic [COEFF_WIDTH-1:0]         smooth_c, attack_c, release_c, highpass_c;

  logic signed [SAMPLE_WIDTH-1:0] x;
  logic signed [SAMPLE_WIDTH-1:0] prev_sample;
  logic                           div_sign;
  logic [LEVEL_W-1:0]             env;
  logic [SAMPLE_WIDTH-1:0]        hp_last_in;
  logic signed [HP_W-1:0]         hp_last_out;
  logic [LEVEL_W-1:0]             sm_sub, sm_upper, sm_dry;
  logic signed [SUM_W-1:0]        sum;
  logic signed [PROD_W-1:0]       prod;

  logic [SAMPLE_WIDTH-1:0]        mag;
  logic [LEVEL_W-1:0]             env_tgt;
  logic signed [MUL_W-1:0]        mul_a, mul_b;
  logic signed [PROD_W-1:0]       prod_sh;
  logic signed [HP_SUM_W-1:0]     hp_sum;
  logic signed [HP_W-1:0]         hp_sat;
  logic signed [SUM_W-1:0]        t2;
  logic signed [SUM_W-1:0]        mix_rnd;
  logic [SAMPLE_WIDTH-1:0]        mix_sat;
  logic                           mix_clip;

  function automatic logic [SAMPLE_WIDTH-1:0] level_reg(input logic [SAMPLE_WIDTH-1:0] v);
    return (v > UNITY) ? UNITY : v;
  endfunction

  function automatic logic signed [MUL_W-1:0] lvl_diff(input logic [LEVEL_W-1:0] tgt,
                                                       input logic [LEVEL_W-1:0] cur);
    return $signed({1'b0, tgt}) - $signed({1'b0, cur});
  endfunction

  function automatic logic signed [MUL_W-1:0] coeff_op(input logic [COEFF_WIDTH-1:0] c);
    return $signed({{(MUL_W - COEFF_WIDTH){1'b0}}, c});
  endfunction

  function automatic logic signed [MUL_W-1:0] level_op(input logic [LEVEL_W-1:0] l);
    return $signed({1'b0, l});
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b1;
      sub_lvl    <= SUB_LEVEL_RST;
      upper_lvl  <= UPPER_LEVEL_RST;
      dry_lvl    <= DRY_LEVEL_RST;
      smooth_c   <= SMOOTH_RST;
      attack_c   <= ATTACK_RST;
      release_c  <= RELEASE_RST;
      highpass_c <= HIGHPASS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ENABLE:      enable     <= cfg_data[0];
        REG_SUB_LEVEL:   sub_lvl    <= level_reg(cfg_data);
        REG_UPPER_LEVEL: upper_lvl  <= level_reg(cfg_data);
        REG_DRY_LEVEL:   dry_lvl    <= level_reg(cfg_data);
        REG_SMOOTH:      smooth_c   <= cfg_data[COEFF_WIDTH-1:0];
        REG_ATTACK:      attack_c   <= cfg_data[COEFF_WIDTH-1:0];
        REG_RELEASE:     release_c  <= cfg_data[COEFF_WIDTH-1:0];
        REG_HIGHPASS:    highpass_c <= cfg_data[COEFF_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign mag     = x[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-x) : x;
  assign env_tgt = {mag, {EXT_BITS{1'b0}}};

  always_comb begin
    unique case (cmd.mul_op)
      MUL_SUB: begin
        mul_a = coeff_op(smooth_c);
        mul_b = lvl_diff({sub_lvl, {EXT_BITS{1'b0}}}, sm_sub);
      end
      MUL_UPPER: begin
        mul_a = coeff_op(smooth_c);
        mul_b = lvl_diff({upper_lvl, {EXT_BITS{1'b0}}}, sm_upper);
      end
      MUL_DRY: begin
        mul_a = coeff_op(smooth_c);
        mul_b = lvl_diff({dry_lvl, {EXT_BITS{1'b0}}}, sm_dry);
      end
      MUL_ENV: begin
        mul_a = coeff_op((env_tgt > env) ? attack_c : release_c);
        mul_b = lvl_diff(env_tgt, env);
      end
      MUL_HP: begin
        mul_a = coeff_op(highpass_c);
        mul_b = {{(MUL_W - HP_W){hp_last_out[HP_W-1]}}, hp_last_out};
      end
      MUL_T1: begin
        mul_a = {{(MUL_W - SAMPLE_WIDTH){x[SAMPLE_WIDTH-1]}}, x};
        mul_b = level_op(sm_dry);
      end
      MUL_T2: begin
        mul_a = level_op(env);
        mul_b = level_op(sm_sub);
      end
      MUL_T3: begin
        mul_a = {{(MUL_W - HP_W){hp_last_out[HP_W-1]}}, hp_last_out};
        mul_b = level_op(sm_upper);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign prod_sh = prod >>> COEFF_WIDTH;
  assign hp_sum  = $signed({{(HP_SUM_W - SAMPLE_WIDTH){1'b0}}, mag})
                 - $signed({{(HP_SUM_W - SAMPLE_WIDTH){1'b0}}, hp_last_in})
                 + HP_SUM_W'(prod_sh);

  always_comb begin
    priority if (hp_sum > HP_MAX) begin
      hp_sat = HP_W'(HP_MAX);
    end else if (hp_sum < HP_MIN) begin
      hp_sat = HP_W'(HP_MIN);
    end else begin
      hp_sat = HP_W'(hp_sum);
    end
  end

  assign t2      = SUM_W'(prod_sh);
  assign mix_rnd = (sum + MIX_HALF) >>> MIX_SHIFT;

  always_comb begin
    mix_clip = 1'b1;
    priority if (mix_rnd > OUT_MAX) begin
      mix_sat = SAMPLE_WIDTH'(OUT_MAX);
    end else if (mix_rnd < OUT_MIN) begin
      mix_sat = SAMPLE_WIDTH'(OUT_MIN);
    end else begin
      mix_sat  = SAMPLE_WIDTH'(mix_rnd);
      mix_clip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x <= sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample <= '0;
      div_sign    <= 1'b0;
      env         <= '0;
      hp_last_in  <= '0;
      hp_last_out <= '0;
      sm_sub      <= {SUB_LEVEL_RST, {EXT_BITS{1'b0}}};
      sm_upper    <= {UPPER_LEVEL_RST, {EXT_BITS{1'b0}}};
      sm_dry      <= {DRY_LEVEL_RST, {EXT_BITS{1'b0}}};
    end else begin
      if (cmd.upd_div) begin
        if (prev_sample < -HYST && x > HYST) begin
          div_sign <= ~div_sign;
        end
        prev_sample <= x;
      end
      unique case (cmd.wb_op)
        WB_SUB:   sm_sub   <= sm_sub + LEVEL_W'(prod_sh);
        WB_UPPER: sm_upper <= sm_upper + LEVEL_W'(prod_sh);
        WB_DRY:   sm_dry   <= sm_dry + LEVEL_W'(prod_sh);
        WB_ENV:   env      <= env + LEVEL_W'(prod_sh);
        WB_HP: begin
          hp_last_in  <= mag;
          hp_last_out <= hp_sat;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.wb_op)
      WB_T1:   sum <= SUM_W'(prod);
      WB_T2:   sum <= div_sign ? sum - t2 : sum + t2;
      WB_T3:   sum <= sum + SUM_W'(prod);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sample  <= cmd.pass ? x : mix_sat;
      out_clipped <= cmd.pass ? 1'b0 : mix_clip;
    end
  end

  assign status.enable   = enable;
  assign status.out_free = !out_valid || out_ready;

endmodule

[hdl/octave_divider_effect_core.sv]
// Flip-flop octave divider on a Q1.15 sample stream: one result per sample, the
// saturated mix of the dry signal, a sub-octave square wave scaled by the input
// envelope and a DC-blocked rectified upper octave, with a clip flag in tuser.
// With the effect enabled a sample goes from acceptance through eight product
// steps on one shared 33x33 multiplier (three level glides, envelope, DC blocker,
// three mix terms), one accumulate and one output load before the next sample
// can be accepted. With the effect disabled a sample goes straight to the output
// load and the filter state holds. The result sits in an output register, so the
// next sample is taken while the previous result waits for m_tready.
// Write configuration only while no sample is in flight.
module octave_divider_effect_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [ode_pkg::SAMPLE_WIDTH-1:0] s_tdata,   // [15:0] sample_in
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ode_pkg::SAMPLE_WIDTH-1:0] m_tdata,   // [15:0] sample_out
  output logic                             m_tuser,   // [0] clipped
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ode_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ode_pkg::SAMPLE_WIDTH-1:0] cfg_data
);
  import ode_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  ode_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ode_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .sample_in   (s_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .out_sample  (m_tdata),
    .out_clipped (m_tuser)
  );

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready while a sample is in flight");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared without a sample in flight");

  a_clip_at_rail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata == OUT_MAX[SAMPLE_WIDTH-1:0]) ||
                            (m_tdata == OUT_MIN[SAMPLE_WIDTH-1:0]))
    else $error("clip flag set on an unsaturated sample");

endmodule
